// ===== hdl/aes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES block cipher package
// Shared constants, tables and round functions for the AES cipher block.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int MaxRounds = 14;

  // Register map indexes (byte address / 8)
  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_KEYLEN = 3'd4;

  // Key length codes
  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;
  localparam logic [1:0] KLEN_256 = 2'd2;

  typedef logic [7:0] byte_tab_t [256];

  localparam byte_tab_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
    8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
    8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
    8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
    8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
    8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
    8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
    8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
    8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
    8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
    8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
    8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
    8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
    8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
    8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
    8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
    8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte_tab_t make_inv_sbox();
    byte_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam byte_tab_t INV_SBOX = make_inv_sbox();

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_word(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
            xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_word(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    a[0] = w[31:24]; a[1] = w[23:16]; a[2] = w[15:8]; a[3] = w[7:0];
    for (int k = 0; k < 4; k++) begin
      x2[k]  = xt(a[k]);
      x4[k]  = xt(x2[k]);
      x8[k]  = xt(x4[k]);
      m9[k]  = x8[k] ^ a[k];
      m11[k] = x8[k] ^ x2[k] ^ a[k];
      m13[k] = x8[k] ^ x4[k] ^ a[k];
      m14[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
            m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
            m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
  endfunction

  // Forward round without key addition; byte 0 sits in bits 127:120
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [31:0] w;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      b[i] = SBOX[s[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = b[4*((c+r)%4)+r];
      end
    end
    for (int c = 0; c < 4; c++) begin
      w = {t[4*c], t[4*c+1], t[4*c+2], t[4*c+3]};
      o[127-32*c -: 32] = last ? w : mix_word(w);
    end
    return o;
  endfunction

  // Inverse round of the equivalent inverse cipher, without key addition
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [31:0] w;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      b[i] = INV_SBOX[s[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*((c+r)%4)+r] = b[4*c+r];
      end
    end
    for (int c = 0; c < 4; c++) begin
      w = {t[4*c], t[4*c+1], t[4*c+2], t[4*c+3]};
      o[127-32*c -: 32] = last ? w : inv_mix_word(w);
    end
    return o;
  endfunction

  // Round key write port from the key expander; address fields sized for 15 rows max
  typedef struct packed {
    logic         we;
    logic [3:0]   enc_addr;
    logic [127:0] enc_data;
    logic [3:0]   dec_addr;
    logic [127:0] dec_data;
  } aes_kwr_t;

endpackage

// ===== hdl/aes_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/aes_key_exp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES key expander
// Produces one schedule word per cycle; writes each finished encryption row
// and the matching equivalent-inverse decryption row.
// ----------------------------------------------------------------------------
module aes_key_exp #(
  parameter int MAX_ROUNDS = aes_pkg::MaxRounds,
  parameter int RW         = $clog2(MAX_ROUNDS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [255:0]     key,
  input  logic [1:0]       key_len,
  output logic             busy,
  output logic [RW-1:0]    nr,
  output aes_pkg::aes_kwr_t kwr
);

  localparam int WW = RW + 2;

  logic            busy_r, busy_nxt;
  logic [WW-1:0]   idx_r, idx_nxt;
  logic [2:0]      jm_r, jm_nxt;
  logic [7:0]      rcon_r, rcon_nxt;
  logic [31:0]     win_r [8];
  logic [31:0]     word;
  logic [31:0]     t;
  logic [31:0]     far;
  logic [3:0]      nk;
  logic [RW-1:0]   nr_raw;
  logic [RW-1:0]   row;
  logic [RW-1:0]   drow;
  logic [127:0]    erow;
  logic [31:0]     kw [8];

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      kw[j] = key[255-32*j -: 32];
    end
    case (key_len)
      aes_pkg::KLEN_128: begin
        nk = 4'd4; nr_raw = RW'(10); far = win_r[3];
      end
      aes_pkg::KLEN_192: begin
        nk = 4'd6; nr_raw = RW'(12); far = win_r[5];
      end
      default: begin
        nk = 4'd8; nr_raw = RW'(14); far = win_r[7];
      end
    endcase
    nr = (nr_raw > RW'(MAX_ROUNDS)) ? RW'(MAX_ROUNDS) : nr_raw;
  end

  always_comb begin
    t        = win_r[0];
    rcon_nxt = rcon_r;
    if (jm_r == 3'd0) begin
      t        = aes_pkg::sub_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rcon_r, 24'h0};
      rcon_nxt = aes_pkg::xt(rcon_r);
    end else if (nk == 4'd8 && jm_r == 3'd4) begin
      t = aes_pkg::sub_word(win_r[0]);
    end
    word = (idx_r < WW'(nk)) ? kw[idx_r[2:0]] : (far ^ t);

    jm_nxt   = (jm_r == 3'(nk - 4'd1)) ? 3'd0 : jm_r + 3'd1;
    idx_nxt  = idx_r + WW'(1);
    busy_nxt = busy_r && (idx_r != {nr, 2'b11});
    if (idx_r < WW'(nk)) begin
      rcon_nxt = rcon_r;
    end

    row  = idx_r[WW-1:2];
    drow = nr - row;
    erow = {win_r[2], win_r[1], win_r[0], word};

    kwr.we       = busy_r && (idx_r[1:0] == 2'b11);
    kwr.enc_addr = 4'(row);
    kwr.enc_data = erow;
    kwr.dec_addr = 4'(drow);
    if (row == '0 || row == nr) begin
      kwr.dec_data = erow;
    end else begin
      kwr.dec_data = {aes_pkg::inv_mix_word(erow[127:96]), aes_pkg::inv_mix_word(erow[95:64]),
                      aes_pkg::inv_mix_word(erow[63:32]), aes_pkg::inv_mix_word(erow[31:0])};
    end
  end

  // Restart from word 0 on reset and on every start (each write to a known register)
  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      jm_r   <= 3'd0;
      rcon_r <= 8'h01;
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      jm_r   <= jm_nxt;
      rcon_r <= rcon_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      win_r[0] <= word;
      for (int k = 1; k < 8; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  assign busy = busy_r;

endmodule

// ===== hdl/aes_block_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES block cipher
// Usage: write the key (key_part_0..3 at 0x00..0x18) and key_length (0x20,
// 0 = 128, 1 = 192, 2 = 256 bit) over the APB port. Each write to a known
// register reruns the key expander, which holds in_tready low while it
// runs; after reset it runs once on the all-zero 128 bit key. Round keys
// sit in two 128-bit wide RAMs, one row per round: encryption keys and
// equivalent-inverse decryption keys.
// Input transaction: in_tdata carries the block, in_tuser selects encrypt (0)
// or decrypt (1). The datapath applies one round per cycle, reading one
// round key row per cycle from RAM; a block is taken in the idle state, runs
// through the round loop and then moves to the output register, and a new
// block is accepted only once the previous one has left the round loop.
// Output transaction: out_tdata holds the result in an output register.
// When the receiver stalls, the next block is still accepted and processed;
// it holds in the round register until the output register frees.
// ----------------------------------------------------------------------------
module aes_block_cipher #(
  parameter int MAX_ROUNDS = aes_pkg::MaxRounds
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] block_high, [127:64] block_low
  input  logic         in_tuser,   // [0] action
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [63:0] result_high, [127:64] result_low
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int RW    = $clog2(MAX_ROUNDS + 1);
  localparam int DEPTH = MAX_ROUNDS + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  // Configuration registers
  logic [63:0] key0_r, key1_r, key2_r, key3_r;
  logic [1:0]  klen_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic        kx_start;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];

  always_comb begin
    kx_start = 1'b0;
    prdata   = '0;
    unique case (cfg_idx)
      aes_pkg::REG_KEY0:   begin prdata = key0_r; kx_start = cfg_wr; end
      aes_pkg::REG_KEY1:   begin prdata = key1_r; kx_start = cfg_wr; end
      aes_pkg::REG_KEY2:   begin prdata = key2_r; kx_start = cfg_wr; end
      aes_pkg::REG_KEY3:   begin prdata = key3_r; kx_start = cfg_wr; end
      aes_pkg::REG_KEYLEN: begin prdata = {62'h0, klen_r}; kx_start = cfg_wr; end
      default:             begin prdata = '0; kx_start = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
      klen_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        aes_pkg::REG_KEY0:   key0_r <= pwdata;
        aes_pkg::REG_KEY1:   key1_r <= pwdata;
        aes_pkg::REG_KEY2:   key2_r <= pwdata;
        aes_pkg::REG_KEY3:   key3_r <= pwdata;
        aes_pkg::REG_KEYLEN: klen_r <= pwdata[1:0];
        default:             ;
      endcase
    end
  end

  // Key expansion into the round key RAMs
  logic              kx_busy;
  logic [RW-1:0]     nr;
  aes_pkg::aes_kwr_t kwr;

  aes_key_exp #(.MAX_ROUNDS(MAX_ROUNDS), .RW(RW)) u_kx (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (kx_start),
    .key     ({key0_r, key1_r, key2_r, key3_r}),
    .key_len (klen_r),
    .busy    (kx_busy),
    .nr      (nr),
    .kwr     (kwr)
  );

  logic [RW-1:0]  raddr;
  logic [127:0]   enc_rkey, dec_rkey;

  aes_ram #(.WIDTH(128), .DEPTH(DEPTH)) u_enc_ram (
    .clk   (clk),
    .we    (kwr.we),
    .waddr (kwr.enc_addr[RW-1:0]),
    .wdata (kwr.enc_data),
    .raddr (raddr),
    .rdata (enc_rkey)
  );

  aes_ram #(.WIDTH(128), .DEPTH(DEPTH)) u_dec_ram (
    .clk   (clk),
    .we    (kwr.we),
    .waddr (kwr.dec_addr[RW-1:0]),
    .wdata (kwr.dec_data),
    .raddr (raddr),
    .rdata (dec_rkey)
  );

  // Round datapath
  logic [1:0]    state_r, state_nxt;
  logic [RW-1:0] rnd_r, rnd_nxt;
  logic          act_r, act_nxt;
  logic [127:0]  s_r, s_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [127:0]  out_data_r, out_data_nxt;
  logic          last;
  logic          out_free;
  logic [127:0]  rkey;
  logic [127:0]  round_out;

  assign in_tready = (state_r == ST_IDLE) && !kx_busy;
  assign last      = (rnd_r == nr);
  assign out_free  = !out_valid_r || out_tready;
  assign rkey      = act_r ? dec_rkey : enc_rkey;

  always_comb begin
    if (rnd_r == '0) begin
      round_out = s_r ^ rkey;
    end else if (act_r) begin
      round_out = aes_pkg::dec_round(s_r, last) ^ rkey;
    end else begin
      round_out = aes_pkg::enc_round(s_r, last) ^ rkey;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    act_nxt       = act_r;
    s_nxt         = s_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    raddr         = '0;
    unique case (state_r)
      ST_IDLE: begin
        // present round key row 0 while the block is taken
        if (in_tvalid && in_tready) begin
          s_nxt     = {in_tdata[63:0], in_tdata[127:64]};
          act_nxt   = in_tuser;
          rnd_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        raddr = last ? rnd_r : rnd_r + RW'(1);
        s_nxt = round_out;
        if (last) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = round_out;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end else begin
          rnd_nxt = rnd_r + RW'(1);
        end
      end
      ST_HOLD: begin
        // hold the finished block until the output register drains
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = s_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rnd_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rnd_r       <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    s_r        <= s_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r[63:0], out_data_r[127:64]};

`ifndef SYNTHESIS
  // Blocks only enter once the key schedule is complete
  a_no_accept_during_kx: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !kx_busy)
    else $error("input taken while key expansion runs");

  // User must not rewrite round key RAMs under a running block; not enforced
  a_no_kwr_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    kwr.we |-> (state_r == ST_IDLE))
    else $error("round key written while a block is in flight");

  // Round counter stays within the schedule length
  a_rnd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (rnd_r <= nr))
    else $error("round counter beyond round count");

  // A finished block reaches the output register when it is free
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && last && out_free) |=> out_tvalid)
    else $error("finished block not presented");
`endif

endmodule
